### rtl/matrix_inverse_3x3_macros.svh
// Assertion macros for the 3x3 matrix inverse block.
// Used by the top level; needs clk_i and rst_ni in scope.
`ifndef MATRIX_INVERSE_3X3_MACROS_SVH
`define MATRIX_INVERSE_3X3_MACROS_SVH
`ifndef ASSERT_OFF
`define MI3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MI3_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define MI3_ASSERT(lbl, prop, msg)
`define MI3_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

### rtl/mi3_pkg.sv
// Shared types, widths and index tables for the 3x3 matrix inverse.
// No dependencies.
`default_nettype none
package mi3_pkg;
  localparam int ElemBits    = 16;
  localparam int CofW        = 2 * ElemBits + 1;
  localparam int ProdW       = CofW + ElemBits;
  localparam int AccW        = ProdW + 2;
  localparam int InvShift    = 24;
  localparam int DetShift    = 8;
  localparam int NumW        = CofW + InvShift;
  localparam int InvW        = 32;
  localparam int DetW        = 48;
  localparam int NumElems    = 9;
  localparam int IdxW        = 4;
  localparam int OpW         = 5;
  localparam int NumMinorOps = 18;
  localparam int NumOps      = 21;
  localparam int DivCntW     = $clog2(NumW + 1);

  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_e;

  typedef struct packed {
    logic    mul_en;
    acc_op_e acc_op;
  } mac_ctrl_t;

  typedef struct packed {
    logic [IdxW-1:0] a;
    logic [IdxW-1:0] b;
  } elem_pair_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_ISSUE, ST_MUL, ST_ACC, ST_STORE, ST_DET, ST_DIVS, ST_DIVW, ST_EMIT
  } st_e;

  // Row-major index of element (rr, cc)
  function automatic logic [IdxW-1:0] elem_index(input logic [1:0] rr, input logic [1:0] cc);
    return {2'b00, rr} + {1'b0, rr, 1'b0} + {2'b00, cc};
  endfunction

  // Split a row-major index into {row, col}
  function automatic logic [3:0] idx_rc(input logic [IdxW-1:0] k);
    logic [3:0] rc;
    case (k)
      4'd0:    rc = {2'd0, 2'd0};
      4'd1:    rc = {2'd0, 2'd1};
      4'd2:    rc = {2'd0, 2'd2};
      4'd3:    rc = {2'd1, 2'd0};
      4'd4:    rc = {2'd1, 2'd1};
      4'd5:    rc = {2'd1, 2'd2};
      4'd6:    rc = {2'd2, 2'd0};
      4'd7:    rc = {2'd2, 2'd1};
      4'd8:    rc = {2'd2, 2'd2};
      default: rc = {2'd0, 2'd0};
    endcase
    return rc;
  endfunction

  // Transposed index: cofactor (c, r) feeds adjugate entry (r, c)
  function automatic logic [IdxW-1:0] transpose_idx(input logic [IdxW-1:0] k);
    logic [3:0] rc;
    rc = idx_rc(k);
    return elem_index(rc[1:0], rc[3:2]);
  endfunction

  // Element operands of each multiply step. Two steps per cofactor; odd
  // cofactors swap the product order so the checkerboard sign comes free.
  // The last three steps take element b of row 0 (cofactor comes from a register).
  function automatic elem_pair_t op_elems(input logic [OpW-1:0] op);
    elem_pair_t p;
    logic [3:0] rc;
    logic [1:0] r0, r1, c0, c1;
    logic       flip;
    rc = idx_rc(op[OpW-1:1]);
    r0 = (rc[3:2] == 2'd0) ? 2'd1 : 2'd0;
    r1 = (rc[3:2] == 2'd2) ? 2'd1 : 2'd2;
    c0 = (rc[1:0] == 2'd0) ? 2'd1 : 2'd0;
    c1 = (rc[1:0] == 2'd2) ? 2'd1 : 2'd2;
    flip = op[0] ^ rc[2] ^ rc[0];
    if (op >= OpW'(NumMinorOps)) begin
      p.a = '0;
      p.b = IdxW'(op - OpW'(NumMinorOps));
    end else if (flip) begin
      p.a = elem_index(r0, c1);
      p.b = elem_index(r1, c0);
    end else begin
      p.a = elem_index(r0, c0);
      p.b = elem_index(r1, c1);
    end
    return p;
  endfunction
endpackage
`default_nettype wire

### rtl/mi3_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mi3_ram #(
  parameter int Width = 16,
  parameter int Depth = 9
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/mi3_mac.sv
// Shared signed multiply-accumulate unit: registered product, then accumulate.
// Depends on mi3_pkg.
`default_nettype none
module mi3_mac import mi3_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire mac_ctrl_t              ctrl_i,
  input  wire logic signed [CofW-1:0] a_i,
  input  wire logic signed [ElemBits-1:0] b_i,
  output logic signed [AccW-1:0]      acc_o
);
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  prod_ext;
  logic signed [AccW-1:0]  acc_q, acc_d;

  assign prod_ext = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};

  // Select the accumulate operation
  always_comb begin
    case (ctrl_i.acc_op)
      ACC_LOAD: acc_d = prod_ext;
      ACC_ADD:  acc_d = acc_q + prod_ext;
      ACC_SUB:  acc_d = acc_q - prod_ext;
      default:  acc_d = acc_q;
    endcase
  end

  // Hold the product
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= a_i * b_i;
    end
  end

  // Hold the accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;
endmodule
`default_nettype wire

### rtl/mi3_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mi3_pkg.
`default_nettype none
module mi3_div import mi3_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [AccW-1:0] den_i,
  output logic                 done_o,
  output logic [NumW-1:0]      quo_o
);
  logic               run_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [AccW:0]      rem_q;
  logic [AccW-1:0]    den_q;
  logic [NumW-1:0]    nq_q;
  logic [AccW:0]      rem_sh;
  logic               ge;

  // Shift in the next numerator bit and trial-subtract
  assign rem_sh = {rem_q[AccW-1:0], nq_q[NumW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  // Advance the control count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == DivCntW'(1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= DivCntW'(NumW);
      end else if (run_q) begin
        cnt_q <= cnt_q - DivCntW'(1);
        if (cnt_q == DivCntW'(1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      nq_q  <= num_i;
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
      nq_q  <= {nq_q[NumW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = nq_q;
endmodule
`default_nettype wire

### rtl/matrix_inverse_3x3.sv
// Top level of the 3x3 matrix inverse: sequencer, element RAMs, cofactor registers.
// Depends on mi3_pkg, mi3_ram, mi3_mac, mi3_div and the assertion macro header.
`default_nettype none
`include "matrix_inverse_3x3_macros.svh"
// Load nine Q8.8 elements one per request (start high while busy is low); the
// ninth raises busy. The block then runs 21 multiply steps on its one shared
// multiply-accumulate unit, each through issue, multiply and accumulate states;
// each cofactor is stored after its second step, then the determinant is taken.
// Each of the nine results then takes one pass of the shared bit-serial divider
// plus a handoff; a singular matrix skips the divider and gives zero results.
// Results appear for one cycle each on strobe_o, in row-major order; the
// receiver cannot stall them. busy drops with the last result's cycle, and
// loading may resume.
module matrix_inverse_3x3 import mi3_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic signed [ElemBits-1:0] element_value_i,
  output logic                            strobe_o,
  output logic signed [InvW-1:0]          inverse_element_o,
  output logic signed [DetW-1:0]          determinant_o,
  output logic                            singular_o,
  output logic                            last_of_run_o
);
  st_e               state_q, state_d;
  logic [IdxW-1:0]   cnt_q, cnt_d;
  logic [OpW-1:0]    op_q, op_d;
  logic [IdxW-1:0]   k_q, k_d;
  logic [CofW-1:0]   cof_q [NumElems];
  logic              sing_q;
  logic              dneg_q;
  logic              neg_q;
  logic [AccW-1:0]   mdet_q;
  logic [DetW-1:0]   detbits_q;
  logic              load_req;
  elem_pair_t        pair;
  logic [ElemBits-1:0] ram_a, ram_b;
  mac_ctrl_t         mac_ctrl;
  logic signed [CofW-1:0] mac_a;
  logic signed [AccW-1:0] acc;
  logic [IdxW-1:0]   cof_idx;
  logic [CofW-1:0]   cof_rd;
  logic [CofW-1:0]   cof_mag;
  logic              div_start, div_done;
  logic [NumW-1:0]   quo;
  logic [AccW-1:0]   det_mag;
  logic [AccW+DetShift-1:0] dout;
  logic [DetW-1:0]   det_bits;
  logic              q_pos_sat, q_neg_sat;
  logic [InvW-1:0]   q_mag, inv_val;
  logic              strobe_q, last_q, singular_q;
  logic [InvW-1:0]   inv_q;
  logic [DetW-1:0]   det_out_q;

  assign load_req = start && !busy;
  assign busy     = (state_q != ST_LOAD);
  assign pair     = op_elems(op_q);

  // Two copies of the element store so both operands read in the same cycle
  mi3_ram #(.Width(ElemBits), .Depth(NumElems)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (load_req),
    .waddr_i (cnt_q),
    .wdata_i (element_value_i),
    .raddr_i (pair.a),
    .rdata_o (ram_a)
  );

  mi3_ram #(.Width(ElemBits), .Depth(NumElems)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (load_req),
    .waddr_i (cnt_q),
    .wdata_i (element_value_i),
    .raddr_i (pair.b),
    .rdata_o (ram_b)
  );

  // Single cofactor read point: transposed entry while dividing, row 0 for det
  assign cof_idx = (state_q == ST_DIVS) ? transpose_idx(k_q)
                                        : IdxW'(op_q - OpW'(NumMinorOps));
  assign cof_rd  = cof_q[cof_idx];
  assign cof_mag = cof_rd[CofW-1] ? (~cof_rd + CofW'(1)) : cof_rd;

  assign mac_a = (op_q >= OpW'(NumMinorOps)) ? signed'(cof_rd)
               : signed'({{(CofW-ElemBits){ram_a[ElemBits-1]}}, ram_a});

  mi3_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (signed'(ram_b)),
    .acc_o  (acc)
  );

  assign div_start = (state_q == ST_DIVS);

  mi3_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({cof_mag, {InvShift{1'b0}}}),
    .den_i   (mdet_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Determinant magnitude and saturated Q16.32 field
  always_comb begin
    logic big;
    det_mag = acc[AccW-1] ? (~acc + AccW'(1)) : acc;
    dout    = {det_mag, {DetShift{1'b0}}};
    if (acc[AccW-1]) begin
      big = (|dout[AccW+DetShift-1:DetW]) || (dout[DetW-1] && (|dout[DetW-2:0]));
      det_bits = big ? (DetW'(0) - {1'b1, {(DetW-1){1'b0}}}) : (DetW'(0) - dout[DetW-1:0]);
    end else begin
      big = |dout[AccW+DetShift-1:DetW-1];
      det_bits = big ? {1'b0, {(DetW-1){1'b1}}} : dout[DetW-1:0];
    end
  end

  // Saturate the quotient into Q16.16
  always_comb begin
    q_pos_sat = |quo[NumW-1:InvW-1];
    q_neg_sat = (|quo[NumW-1:InvW]) || (quo[InvW-1] && (|quo[InvW-2:0]));
    q_mag     = q_neg_sat ? {1'b1, {(InvW-1){1'b0}}} : quo[InvW-1:0];
    if (sing_q) begin
      inv_val = '0;
    end else if (neg_q) begin
      inv_val = InvW'(0) - q_mag;
    end else begin
      inv_val = q_pos_sat ? {1'b0, {(InvW-1){1'b1}}} : quo[InvW-1:0];
    end
  end

  // Next state of the sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    op_d    = op_q;
    k_d     = k_q;
    unique case (state_q)
      ST_LOAD: begin
        if (load_req) begin
          if (cnt_q == IdxW'(NumElems - 1)) begin
            cnt_d   = '0;
            op_d    = '0;
            state_d = ST_ISSUE;
          end else begin
            cnt_d = cnt_q + IdxW'(1);
          end
        end
      end
      ST_ISSUE: state_d = ST_MUL;
      ST_MUL:   state_d = ST_ACC;
      ST_ACC: begin
        if (op_q < OpW'(NumMinorOps) && op_q[0]) begin
          state_d = ST_STORE;
        end else if (op_q == OpW'(NumOps - 1)) begin
          state_d = ST_DET;
        end else begin
          op_d    = op_q + OpW'(1);
          state_d = ST_ISSUE;
        end
      end
      ST_STORE: begin
        op_d    = op_q + OpW'(1);
        state_d = ST_ISSUE;
      end
      ST_DET: begin
        k_d     = '0;
        state_d = (acc == '0) ? ST_EMIT : ST_DIVS;
      end
      ST_DIVS: state_d = ST_DIVW;
      ST_DIVW: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (k_q == IdxW'(NumElems - 1)) begin
          state_d = ST_LOAD;
        end else begin
          k_d     = k_q + IdxW'(1);
          state_d = sing_q ? ST_EMIT : ST_DIVS;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Drive the multiply-accumulate unit
  always_comb begin
    mac_ctrl.mul_en = 1'b0;
    mac_ctrl.acc_op = ACC_HOLD;
    unique case (state_q)
      ST_MUL: mac_ctrl.mul_en = 1'b1;
      ST_ACC: begin
        if (op_q >= OpW'(NumMinorOps)) begin
          mac_ctrl.acc_op = (op_q == OpW'(NumMinorOps)) ? ACC_LOAD : ACC_ADD;
        end else begin
          mac_ctrl.acc_op = op_q[0] ? ACC_SUB : ACC_LOAD;
        end
      end
      default: begin
        mac_ctrl.mul_en = 1'b0;
        mac_ctrl.acc_op = ACC_HOLD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      cnt_q    <= '0;
      op_q     <= '0;
      k_q      <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      op_q     <= op_d;
      k_q      <= k_d;
      strobe_q <= (state_q == ST_EMIT);
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_STORE) begin
      cof_q[op_q[OpW-1:1]] <= acc[CofW-1:0];
    end
    if (state_q == ST_DET) begin
      sing_q    <= (acc == '0);
      dneg_q    <= acc[AccW-1];
      mdet_q    <= det_mag;
      detbits_q <= (acc == '0) ? '0 : det_bits;
    end
    if (state_q == ST_DIVS) begin
      neg_q <= cof_rd[CofW-1] ^ dneg_q;
    end
    if (state_q == ST_EMIT) begin
      inv_q      <= inv_val;
      det_out_q  <= detbits_q;
      singular_q <= sing_q;
      last_q     <= (k_q == IdxW'(NumElems - 1));
    end
  end

  assign strobe_o          = strobe_q;
  assign inverse_element_o = signed'(inv_q);
  assign determinant_o     = signed'(det_out_q);
  assign singular_o        = singular_q;
  assign last_of_run_o     = last_q;

  // Checks
  `MI3_ASSERT(a_sing_zero, strobe_o && singular_o |-> inverse_element_o == '0, "singular result not zero")
  `MI3_ASSERT(a_ninth_busy, load_req && cnt_q == IdxW'(NumElems - 1) |=> busy, "ninth load did not start work")
  `MI3_ASSERT(a_busy_run, strobe_o && !last_of_run_o |-> busy, "block idle in mid-run")
  `MI3_ASSERT_NEVER(a_strobe_load, strobe_o && state_q == ST_LOAD && !last_of_run_o, "stray result")
endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for matrix_inverse_3x3: loads 3x3 Q8.8 matrices and
// checks every Q16.16 inverse element, determinant and flag against a predictor.
// Depends on mi3_pkg and the matrix_inverse_3x3 RTL.
`timescale 1ns / 100ps

class inverse_scoreboard;
  typedef struct {
    logic signed [31:0] inv;
    logic signed [47:0] det;
    logic               sing;
    logic               last;
  } inverse_result_t;

  logic signed [15:0] matrix[9];
  int unsigned        load_count;
  inverse_result_t    expected_q[$];
  int unsigned        error_count;

  function new();
    load_count  = 0;
    error_count = 0;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  // Store one element; on the ninth, predict the nine inverse results
  function void note_element(logic signed [15:0] value);
    logic signed [127:0] cof[3][3];
    logic signed [127:0] m, det, mdet, dout, a, q;
    logic signed [47:0]  det_bits;
    logic signed [31:0]  inv_bits;
    int                  r0, r1, c0, c1;
    inverse_result_t     res;
    matrix[load_count] = value;
    load_count++;
    if (load_count < 9) return;
    load_count = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        r0 = (r == 0) ? 1 : 0;
        r1 = (r == 2) ? 1 : 2;
        c0 = (c == 0) ? 1 : 0;
        c1 = (c == 2) ? 1 : 2;
        m = 128'(matrix[r0*3+c0]) * 128'(matrix[r1*3+c1])
          - 128'(matrix[r0*3+c1]) * 128'(matrix[r1*3+c0]);
        cof[r][c] = ((r + c) % 2 == 1) ? -m : m;
      end
    end
    det = cof[0][0] * 128'(matrix[0]) + cof[0][1] * 128'(matrix[1])
        + cof[0][2] * 128'(matrix[2]);
    mdet = (det < 0) ? -det : det;
    dout = mdet <<< 8;
    // Saturate the Q16.32 determinant toward the nearest limit
    if (det < 0) begin
      det_bits = (dout > (128'sd1 <<< 47)) ? 48'sh8000_0000_0000 : -48'(dout);
    end else begin
      det_bits = (dout > (128'sd1 <<< 47) - 1) ? 48'sh7FFF_FFFF_FFFF : 48'(dout);
    end
    for (int k = 0; k < 9; k++) begin
      inv_bits = '0;
      if (det != 0) begin
        a = cof[k % 3][k / 3];
        q = (((a < 0) ? -a : a) <<< 24) / mdet;
        if ((a < 0) != (det < 0)) begin
          inv_bits = (q > (128'sd1 <<< 31)) ? 32'sh8000_0000 : -32'(q);
        end else begin
          inv_bits = (q > (128'sd1 <<< 31) - 1) ? 32'sh7FFF_FFFF : 32'(q);
        end
      end
      res.inv  = inv_bits;
      res.det  = (det == 0) ? '0 : det_bits;
      res.sing = (det == 0);
      res.last = (k == 8);
      expected_q.push_back(res);
    end
  endfunction

  // Compare one strobed result with the oldest prediction
  function void check_result(logic signed [31:0] inv, logic signed [47:0] det,
                             logic sing, logic last);
    inverse_result_t exp_r;
    if (expected_q.size() == 0) begin
      $error("unexpected result: inverse_element %0d", inv);
      error_count++;
      return;
    end
    exp_r = expected_q.pop_front();
    if (inv !== exp_r.inv) begin
      $error("inverse_element: expected %0d, actual %0d", exp_r.inv, inv);
      error_count++;
    end
    if (det !== exp_r.det) begin
      $error("determinant: expected %0d, actual %0d", exp_r.det, det);
      error_count++;
    end
    if (sing !== exp_r.sing) begin
      $error("singular: expected %0b, actual %0b", exp_r.sing, sing);
      error_count++;
    end
    if (last !== exp_r.last) begin
      $error("last_of_run: expected %0b, actual %0b", exp_r.last, last);
      error_count++;
    end
  endfunction
endclass

module tb;
  import mi3_pkg::*;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic signed [ElemBits-1:0] element_value_i = '0;
  logic                       strobe_o;
  logic signed [InvW-1:0]     inverse_element_o;
  logic signed [DetW-1:0]     determinant_o;
  logic                       singular_o;
  logic                       last_of_run_o;

  inverse_scoreboard sb = new();
  bit                idle_enable = 1'b1;

  matrix_inverse_3x3 u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .element_value_i  (element_value_i),
    .strobe_o         (strobe_o),
    .inverse_element_o(inverse_element_o),
    .determinant_o    (determinant_o),
    .singular_o       (singular_o),
    .last_of_run_o    (last_of_run_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Check each strobed result at the edge that ends its cycle
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      sb.check_result(inverse_element_o, determinant_o, singular_o, last_of_run_o);
    end
  end

  // Send one element request, with an occasional idle burst ahead of it
  task automatic send_element(logic signed [15:0] value);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    start           <= 1'b1;
    element_value_i <= value;
    do @(posedge clk_i); while (busy);
    sb.note_element(value);
  endtask

  task automatic send_matrix(logic signed [15:0] m[9]);
    for (int i = 0; i < 9; i++) send_element(m[i]);
  endtask

  // Random matrix: full range, small values, or a repeated row (singular)
  task automatic send_random_matrix();
    logic signed [15:0] m[9];
    int                 mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      if (mode < 5) m[i] = 16'($urandom);
      else m[i] = 16'($signed($urandom_range(0, 1024)) - 512);
    end
    if (mode == 9) begin
      for (int i = 0; i < 3; i++) m[6+i] = m[3+i];
    end
    send_matrix(m);
  endtask

  initial begin
    logic signed [15:0] m[9];
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity, zero, all-min singular, determinant overflow both signs
    m = '{256, 0, 0, 0, 256, 0, 0, 0, 256};                         send_matrix(m);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                               send_matrix(m);
    m = '{-32768, -32768, -32768, -32768, -32768, -32768,
          -32768, -32768, -32768};                                  send_matrix(m);
    m = '{32767, 0, 0, 0, 32767, 0, 0, 0, 32767};                   send_matrix(m);
    m = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768};                send_matrix(m);
    // Tiny determinant with large cofactors: inverse saturates
    m = '{32767, 32766, 0, 32766, 32765, 0, 0, 0, 1};               send_matrix(m);
    m = '{32767, -32768, 1, -1, 32767, -32768, 0, 1, -1};           send_matrix(m);

    // Hold off until every result is out
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);

    for (int n = 0; n < 36; n++) begin
      if (n == 30) idle_enable = 1'b0;
      send_random_matrix();
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
